>>> src/lzsswd_pkg.sv
// ----------------------------------------------------------------------------
// LZSS window decoder package
// Shared constants and the command passed from the parser to the copy engine.
// ----------------------------------------------------------------------------
package lzsswd_pkg;

  localparam int WIN_AW = 12;
  localparam int WIN_DEPTH = 1 << WIN_AW;
  localparam logic [WIN_AW-1:0] START_POS = 12'hFEE;
  localparam int LEN_W = 24;
  localparam int RUN_W = 5;
  localparam logic [RUN_W-1:0] LAST_OFS = 5'd2;
  localparam logic [3:0] FLAG_COUNT = 4'd8;

  typedef struct packed {
    logic              start;
    logic              lit;
    logic [WIN_AW-1:0] src;
    logic [3:0]        len_code;
    logic [7:0]        data;
  } cmd_t;

endpackage

>>> src/lzsswd_front.sv
// ----------------------------------------------------------------------------
// LZSS window decoder parser
// Splits the byte stream into flag bytes, literals and two-byte references.
// ----------------------------------------------------------------------------
module lzsswd_front
  import lzsswd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_start,
  input  logic       cmd_space,
  output logic       cmd_push,
  output cmd_t       cmd
);

  logic [7:0] flag_shift, flag_shift_next;
  logic [3:0] flags_left, flags_left_next;
  logic       ref_pending, ref_pending_next;
  logic [7:0] ref_low_byte, ref_low_byte_next;
  logic       start_pending, start_pending_next;
  logic       take;
  logic       gen;

  assign in_ready = cmd_space;
  assign take = in_valid && in_ready;

  always_comb begin
    logic [7:0] eff_shift;
    logic [3:0] eff_left;
    logic       eff_pend;
    logic [7:0] eff_low;
    eff_shift = in_start ? 8'h00 : flag_shift;
    eff_left = in_start ? 4'd0 : flags_left;
    eff_pend = in_start ? 1'b0 : ref_pending;
    eff_low = in_start ? 8'h00 : ref_low_byte;
    flag_shift_next = eff_shift;
    flags_left_next = eff_left;
    ref_pending_next = eff_pend;
    ref_low_byte_next = eff_low;
    gen = 1'b0;
    cmd.start = start_pending || in_start;
    cmd.lit = 1'b0;
    cmd.src = {in_byte[7:4], eff_low};
    cmd.len_code = in_byte[3:0];
    cmd.data = in_byte;
    if (eff_left == 4'd0) begin
      flag_shift_next = in_byte;
      flags_left_next = FLAG_COUNT;
    end else if (eff_pend) begin
      gen = 1'b1;
      ref_pending_next = 1'b0;
      flag_shift_next = eff_shift >> 1;
      flags_left_next = eff_left - 4'd1;
    end else if (eff_shift[0]) begin
      gen = 1'b1;
      cmd.lit = 1'b1;
      flag_shift_next = eff_shift >> 1;
      flags_left_next = eff_left - 4'd1;
    end else begin
      ref_low_byte_next = in_byte;
      ref_pending_next = 1'b1;
    end
    start_pending_next = gen ? 1'b0 : (start_pending || in_start);
  end

  assign cmd_push = take && gen;

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_shift <= '0;
      flags_left <= '0;
      ref_pending <= 1'b0;
      ref_low_byte <= '0;
      start_pending <= 1'b0;
    end else if (take) begin
      flag_shift <= flag_shift_next;
      flags_left <= flags_left_next;
      ref_pending <= ref_pending_next;
      ref_low_byte <= ref_low_byte_next;
      start_pending <= start_pending_next;
    end
  end

endmodule

>>> src/lzsswd_queue.sv
// ----------------------------------------------------------------------------
// LZSS window decoder command queue
// Small register FIFO between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzsswd_queue
  import lzsswd_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic space,
  input  logic pop,
  output logic avail,
  output cmd_t head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  cmd_t          entries [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign space = (count != FULL_CNT);
  assign avail = (count != '0);
  assign head = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> space || pop)
    else $error("command queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> avail)
    else $error("command queue underflow");
`endif

endmodule

>>> src/lzsswd_back.sv
// ----------------------------------------------------------------------------
// LZSS window decoder copy engine
// Reads the history window, writes decoded bytes back and emits them.
// ----------------------------------------------------------------------------
module lzsswd_back
  import lzsswd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic [LEN_W-1:0] output_length,
  input  logic             cmd_avail,
  input  cmd_t             cmd,
  output logic             cmd_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             out_done
);

  logic [7:0]        mem [WIN_DEPTH];
  logic [7:0]        mem_q;
  logic [WIN_AW-1:0] wp;
  logic [WIN_AW:0]   fill;
  logic [LEN_W-1:0]  bytes_emitted;
  logic [RUN_W-1:0]  k;

  logic              w_valid;
  logic              w_use_byte;
  logic [7:0]        w_byte;
  logic              w_rd_ok;
  logic              w_last;
  logic [7:0]        w_value;

  logic              first;
  logic              cmd_last_byte;
  logic              out_free;
  logic              commit;
  logic              advance;
  logic              issue;
  logic              clearing;
  logic [WIN_AW-1:0] rd_addr;
  logic [WIN_AW-1:0] rd_offset;
  logic              rd_in_range;
  logic              fwd_hit;
  logic              emit;
  logic [LEN_W-1:0]  emitted_inc;

  assign first = (k == '0);
  assign cmd_last_byte = cmd.lit || (k == {1'b0, cmd.len_code} + LAST_OFS);
  assign out_free = !out_valid || out_ready;
  assign commit = w_valid && out_free;
  assign advance = !w_valid || out_free;
  assign issue = cmd_avail && advance && !(cmd.start && first && w_valid);
  assign clearing = issue && cmd.start && first;
  assign cmd_pop = issue && cmd_last_byte;

  assign rd_addr = cmd.src + WIN_AW'(k);
  assign rd_offset = rd_addr - START_POS;
  assign rd_in_range = fill[WIN_AW] || ({1'b0, rd_offset} < fill);
  assign fwd_hit = commit && (rd_addr == wp);

  assign w_value = w_use_byte ? w_byte : (w_rd_ok ? mem_q : 8'h00);
  assign emit = (bytes_emitted < output_length);
  assign emitted_inc = bytes_emitted + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (commit) begin
      mem[wp] <= w_value;
    end
    if (issue) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      w_use_byte <= cmd.lit || fwd_hit;
      w_byte <= cmd.lit ? cmd.data : w_value;
      w_rd_ok <= !clearing && rd_in_range;
      w_last <= cmd_last_byte;
    end
    if (commit && emit) begin
      out_byte <= w_value;
      out_done <= (emitted_inc == output_length);
      out_last <= w_last || (emitted_inc == output_length);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= START_POS;
      fill <= '0;
      bytes_emitted <= '0;
      k <= '0;
      w_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        k <= cmd_last_byte ? '0 : k + RUN_W'(1);
      end
      if (issue) begin
        w_valid <= 1'b1;
      end else if (commit) begin
        w_valid <= 1'b0;
      end
      if (commit && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (clearing) begin
        wp <= START_POS;
        fill <= '0;
        bytes_emitted <= '0;
      end else if (commit) begin
        wp <= wp + WIN_AW'(1);
        if (!fill[WIN_AW]) begin
          fill <= fill + (WIN_AW + 1)'(1);
        end
        if (emit) begin
          bytes_emitted <= emitted_inc;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    w_valid && !commit |=> w_valid && $stable(w_value))
    else $error("stalled window byte changed");
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= (WIN_AW + 1)'(WIN_DEPTH))
    else $error("fill count beyond window size");
  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    cmd_avail && !cmd.lit |-> k <= {1'b0, cmd.len_code} + LAST_OFS)
    else $error("copy counter ran past reference length");
`endif

endmodule

>>> src/lzsswd_pkg_top_note.sv
// ----------------------------------------------------------------------------
// LZSS window decoder output length register
// Holds the configured decompressed byte count.
// ----------------------------------------------------------------------------
module lzsswd_cfg
  import lzsswd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [LEN_W-1:0] wr_data,
  output logic [LEN_W-1:0] output_length
);

  always_ff @(posedge clk) begin
    if (rst) begin
      output_length <= '0;
    end else if (wr_en) begin
      output_length <= wr_data;
    end
  end

endmodule

>>> src/lzss_window_decoder.sv
// ----------------------------------------------------------------------------
// LZSS window decoder
// Okumura style LZSS decoder with a 4 KiB ring history window.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one compressed byte per transfer in tdata; tuser marks the
//   first byte of a new stream, which clears the window and parsing state.
//   m_axis returns decoded bytes in tdata; tlast marks the last byte caused by
//   one input byte, tuser marks the byte that reaches the configured length.
//   cfg_wr_en/cfg_wr_data write the decompressed length while idle.
// Timing:
//   flag bytes and first reference bytes produce nothing; a literal gives one
//   byte, a reference 3 to 18 bytes, one window byte per cycle unless m_axis
//   stalls, with one read and one write of the window memory each cycle. The
//   first command of a new stream waits for the previous byte to land. First
//   output passes the command queue, the window read register and the output
//   register. A queue of QUEUE_DEPTH commands lets the parser run ahead.
// Reset:
//   rst clears parsing state, the length register and the window fill count;
//   the window then reads as zeros. A stall on m_axis holds the copy engine,
//   and s_axis keeps accepting until the command queue is full.
// ----------------------------------------------------------------------------
module lzss_window_decoder
  import lzsswd_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,  // in_byte
  input  logic             s_axis_tuser,  // stream_start
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // out_byte
  output logic             m_axis_tlast,
  output logic             m_axis_tuser,  // stream_done
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  logic [LEN_W-1:0] output_length;
  cmd_t             push_cmd;
  cmd_t             head_cmd;
  logic             push;
  logic             space;
  logic             pop;
  logic             avail;

  lzsswd_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .wr_en         (cfg_wr_en),
    .wr_data       (cfg_wr_data),
    .output_length (output_length)
  );

  lzsswd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_start  (s_axis_tuser),
    .cmd_space (space),
    .cmd_push  (push),
    .cmd       (push_cmd)
  );

  lzsswd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_cmd),
    .space     (space),
    .pop       (pop),
    .avail     (avail),
    .head      (head_cmd)
  );

  lzsswd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .output_length (output_length),
    .cmd_avail     (avail),
    .cmd           (head_cmd),
    .cmd_pop       (pop),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_byte      (m_axis_tdata),
    .out_last      (m_axis_tlast),
    .out_done      (m_axis_tuser)
  );

endmodule
